// File: sv/srts_pkg.sv
// ----------------------------------------------------------------------------
// srts_pkg: shared types and constants for the sorted record table search
// Record layout, key select codes, word kinds, status codes, sequencer states
// and the key helpers used by the controller.
// ----------------------------------------------------------------------------
package srts_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_BYTES = 8;

	localparam int KEY_W  = 64;
	localparam int YEAR_W = 16;
	localparam int POS_W  = 5;
	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	// keep the top KEY_BYTES bytes of a key, clear the rest
	localparam logic [KEY_W-1:0] KEY_MASK = ~({KEY_W{1'b1}} >> (8 * KEY_BYTES));

	localparam logic [1:0] SEL_TITLE = 2'd0;
	localparam logic [1:0] SEL_NAME  = 2'd1;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_FIND   = 2'd1,
		KIND_LIST   = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NOTFOUND = 2'd1,
		STAT_BADYEAR  = 2'd2,
		STAT_FULL     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_CHK,
		ST_INS_CMP,
		ST_FND_CHK,
		ST_FND_CMP,
		ST_LST_RD,
		ST_LST_LD,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic [KEY_W-1:0]  title;
		logic [KEY_W-1:0]  name;
		logic [YEAR_W-1:0] year;
	} rec_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		rec_t             wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		rec_t             rec;
		logic [POS_W-1:0] position;
		status_t          status;
		logic             last;
	} res_t;

	function automatic logic [KEY_W-1:0] trunc_key(logic [KEY_W-1:0] k);
		return k & KEY_MASK;
	endfunction

	function automatic logic [KEY_W-1:0] key_of(rec_t r, logic [1:0] sel);
		logic [KEY_W-1:0] k;
		unique case (sel)
			SEL_TITLE: k = r.title;
			SEL_NAME:  k = r.name;
			default:   k = {{(KEY_W - YEAR_W){1'b0}}, r.year};
		endcase
		return k;
	endfunction

endpackage

// File: sv/srts_store.sv
// ----------------------------------------------------------------------------
// srts_store: record memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srts_store
	import srts_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output rec_t     rd_data
);

	rec_t mem_q [CAPACITY];
	rec_t rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem_q[req.raddr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: sv/srts_ctrl.sv
// ----------------------------------------------------------------------------
// srts_ctrl: sequencer and shared key comparator
// Walks insert shifts, binary search steps and list reads, one memory access
// per step; insert and search share one 64-bit key compare.
// ----------------------------------------------------------------------------
module srts_ctrl
	import srts_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [KEY_W-1:0]  title_key,
	input  logic [KEY_W-1:0]  name_key,
	input  logic [YEAR_W-1:0] year_value,
	input  logic [KEY_W-1:0]  query_key,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_data,
	output mem_req_t          mreq,
	input  rec_t              rd_data,
	output logic              res_valid,
	input  logic              res_take,
	output res_t              res
);

	ctrl_state_t       state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [1:0]        sel_q;
	rec_t              rec_q;
	logic [KEY_W-1:0]  tgt_q;
	logic [CNT_W-1:0]  pos_q, lo_q, hix_q, mid_q, idx_q;
	res_t              res_q;

	rec_t              rec_in;
	logic [KEY_W-1:0]  rd_key;
	logic              key_gt, key_lt;
	logic [CNT_W:0]    mid_sum;
	logic [CNT_W-1:0]  mid_c;
	logic              accept, cfg_wr, ins_reject, lo_ok;

	assign rec_in = '{title: trunc_key(title_key), name: trunc_key(name_key), year: year_value};

	// shared comparator: stored key against the target key
	assign rd_key = key_of(rd_data, sel_q);
	assign key_gt = rd_key > tgt_q;
	assign key_lt = rd_key < tgt_q;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hix_q} - {{CNT_W{1'b0}}, 1'b1};
	assign mid_c   = mid_sum[CNT_W:1];
	assign lo_ok   = lo_q < hix_q;

	assign in_stall   = (state_q != ST_IDLE);
	assign cfg_ready  = (state_q == ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign ins_reject = (year_value == '0) || (cnt_q >= CNT_W'(CAPACITY));
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mreq      = '0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (kind_t'(kind))
						KIND_INSERT: state_d = ins_reject ? ST_EMIT : ST_INS_CHK;
						KIND_FIND:   state_d = ST_FND_CHK;
						KIND_LIST:   state_d = (cnt_q == '0) ? ST_EMIT : ST_LST_RD;
						KIND_CLEAR:  state_d = ST_EMIT;
					endcase
				end
			end
			ST_INS_CHK: begin
				if (pos_q == '0) begin
					mreq.we    = 1'b1;
					mreq.waddr = '0;
					mreq.wdata = rec_q;
					state_d    = ST_EMIT;
				end else begin
					mreq.re    = 1'b1;
					mreq.raddr = IDX_W'(pos_q - 1'b1);
					state_d    = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				mreq.we    = 1'b1;
				mreq.waddr = pos_q[IDX_W-1:0];
				if (key_gt) begin
					mreq.wdata = rd_data;
					state_d    = ST_INS_CHK;
				end else begin
					mreq.wdata = rec_q;
					state_d    = ST_EMIT;
				end
			end
			ST_FND_CHK: begin
				if (lo_ok) begin
					mreq.re    = 1'b1;
					mreq.raddr = mid_c[IDX_W-1:0];
					state_d    = ST_FND_CMP;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_FND_CMP: begin
				state_d = (!key_gt && !key_lt) ? ST_EMIT : ST_FND_CHK;
			end
			ST_LST_RD: begin
				mreq.re    = 1'b1;
				mreq.raddr = idx_q[IDX_W-1:0];
				state_d    = ST_LST_LD;
			end
			ST_LST_LD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = res_q.last ? ST_IDLE : ST_LST_RD;
				end
			end
		endcase
	end

	// control state: key select and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= SEL_TITLE;
			cnt_q <= '0;
		end else if (cfg_wr) begin
			sel_q <= cfg_data;
			cnt_q <= '0;
		end else begin
			if (accept && kind_t'(kind) == KIND_CLEAR) begin
				cnt_q <= '0;
			end
			if ((state_q == ST_INS_CHK && pos_q == '0) ||
			    (state_q == ST_INS_CMP && !key_gt)) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// working registers, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rec_q <= rec_in;
				pos_q <= cnt_q;
				lo_q  <= '0;
				hix_q <= cnt_q;
				idx_q <= '0;
				if (kind_t'(kind) == KIND_FIND) begin
					tgt_q <= (sel_q == SEL_TITLE || sel_q == SEL_NAME) ?
					         trunc_key(query_key) : query_key;
				end else begin
					tgt_q <= key_of(rec_in, sel_q);
				end
				res_q.rec      <= '0;
				res_q.position <= POS_W'(CAPACITY);
				res_q.last     <= 1'b1;
				unique case (kind_t'(kind))
					KIND_INSERT: res_q.status <= (year_value == '0) ? STAT_BADYEAR : STAT_FULL;
					KIND_FIND:   res_q.status <= STAT_NOTFOUND;
					KIND_LIST:   res_q.status <= STAT_NOTFOUND;
					KIND_CLEAR: begin
						res_q.status   <= STAT_OK;
						res_q.position <= '0;
					end
				endcase
			end
			ST_INS_CHK: begin
				if (pos_q == '0) begin
					res_q <= '{rec: rec_q, position: '0, status: STAT_OK, last: 1'b1};
				end
			end
			ST_INS_CMP: begin
				if (key_gt) begin
					pos_q <= pos_q - 1'b1;
				end else begin
					res_q <= '{rec: rec_q, position: POS_W'(pos_q), status: STAT_OK, last: 1'b1};
				end
			end
			ST_FND_CHK: begin
				mid_q <= mid_c;
			end
			ST_FND_CMP: begin
				if (key_lt) begin
					lo_q <= mid_q + 1'b1;
				end else if (key_gt) begin
					hix_q <= mid_q;
				end else begin
					res_q <= '{rec: rd_data, position: POS_W'(mid_q), status: STAT_OK,
					           last: 1'b1};
				end
			end
			ST_LST_RD: begin
			end
			ST_LST_LD: begin
				res_q <= '{rec: rd_data, position: POS_W'(idx_q), status: STAT_OK,
				           last: (idx_q + 1'b1) == cnt_q};
			end
			ST_EMIT: begin
				if (res_take && !res_q.last) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.we |-> (state_q == ST_INS_CHK || state_q == ST_INS_CMP))
		else $error("store written outside insert");

	a_mid_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FND_CMP |-> (mid_q >= lo_q && mid_q < hix_q))
		else $error("search midpoint outside window");

	a_shift_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INS_CMP |-> (pos_q != '0 && pos_q <= cnt_q))
		else $error("insert slot out of range");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> cnt_q == '0)
		else $error("config write did not empty table");
`endif

endmodule

// File: sv/sorted_record_table_search_core.sv
// ----------------------------------------------------------------------------
// sorted_record_table_search_core: sorted record table with binary search
// Keeps up to CAPACITY records ordered on the selected key; insert, find,
// list and clear words; results leave through a registered output stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one command word per accept. The
//   block stalls the input from accept until its last result word has been
//   handed to the output register.
//   Output channel (out_valid / out_stall): result words, last marks the
//   final word of a command. The output register holds its word while
//   out_stall is high; the sequencer waits until the register frees.
//   Config channel (cfg_valid / cfg_ready): writes sort_field while idle and
//   empties the table.
// Command time follows the record memory accesses (one access per step,
// registered read, compare in the following cycle), plus any output stall;
// a new command is taken only once the previous one is done:
//   insert   a read and a shift write per record moved up (at most
//            CAPACITY-1), then the write of the new record
//   find     a read and compare per search probe (at most
//            log2(CAPACITY)+1), until a hit or an empty window
//   list     a read per record; clear, reject or empty list go straight to the result
//   Result words are registered in the output register when taken.
// Reset: table empty, sort_field = title, output idle. No clearing pass.
// ----------------------------------------------------------------------------
module sorted_record_table_search_core
	import srts_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [KEY_W-1:0]  title_key,
	input  logic [KEY_W-1:0]  name_key,
	input  logic [YEAR_W-1:0] year_value,
	input  logic [KEY_W-1:0]  query_key,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KEY_W-1:0]  out_title,
	output logic [KEY_W-1:0]  out_name,
	output logic [YEAR_W-1:0] out_year,
	output logic [POS_W-1:0]  position,
	output logic [1:0]        status,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        sort_field
);

	mem_req_t mreq;
	rec_t     rd_data;
	logic     res_valid, res_take;
	res_t     res;

	logic     out_valid_q;
	res_t     out_res_q;

	// sequencer plus shared key comparator
	srts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.title_key  (title_key),
		.name_key   (name_key),
		.year_value (year_value),
		.query_key  (query_key),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (sort_field),
		.mreq       (mreq),
		.rd_data    (rd_data),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	// record memory
	srts_store u_store (
		.clk     (clk),
		.req     (mreq),
		.rd_data (rd_data)
	);

	// output register: loads when empty or when its word leaves this cycle
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_title = out_res_q.rec.title;
	assign out_name  = out_res_q.rec.name;
	assign out_year  = out_res_q.rec.year;
	assign position  = out_res_q.position;
	assign status    = out_res_q.status;
	assign last      = out_res_q.last;

endmodule

// File: tb/sorted_record_table_search_checker.sv
// ----------------------------------------------------------------------------
// sorted_record_table_search_checker: result predictor and comparator
// Watches the command, result and config channels of the sorted record table,
// keeps a shadow copy of the table, predicts the result words of every
// accepted command and compares each accepted result word with the oldest
// prediction.
// ----------------------------------------------------------------------------
module sorted_record_table_search_checker
	import srts_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [KEY_W-1:0]  title_key,
	input  logic [KEY_W-1:0]  name_key,
	input  logic [YEAR_W-1:0] year_value,
	input  logic [KEY_W-1:0]  query_key,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [KEY_W-1:0]  out_title,
	input  logic [KEY_W-1:0]  out_name,
	input  logic [YEAR_W-1:0] out_year,
	input  logic [POS_W-1:0]  position,
	input  logic [1:0]        status,
	input  logic              last,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        sort_field,
	output int                fail_count,
	output int                pending_words
);

	rec_t       stored_rec [CAPACITY];
	int         stored_count = 0;
	logic [1:0] key_sel = SEL_TITLE;
	res_t       expected_words [$];

	initial begin
		fail_count = 0;
		pending_words = 0;
	end

	// selector three falls through to year
	function automatic logic [KEY_W-1:0] rec_key(rec_t r);
		case (key_sel)
			SEL_TITLE: return r.title;
			SEL_NAME:  return r.name;
			default:   return {{(KEY_W - YEAR_W){1'b0}}, r.year};
		endcase
	endfunction

	function automatic res_t make_word(rec_t r, int pos, status_t st, logic lst);
		res_t w;
		w.rec = r;
		w.position = POS_W'(pos);
		w.status = st;
		w.last = lst;
		return w;
	endfunction

	task automatic predict_command(logic [1:0] k, logic [KEY_W-1:0] t,
			logic [KEY_W-1:0] n, logic [YEAR_W-1:0] y, logic [KEY_W-1:0] q);
		rec_t             r;
		rec_t             none;
		int               pos;
		int               lo;
		int               hi;
		int               mid;
		bit               hit;
		logic [KEY_W-1:0] qk;
		logic [KEY_W-1:0] v;
		none = '0;
		case (kind_t'(k))
			KIND_INSERT: begin
				r.title = t & KEY_MASK;
				r.name = n & KEY_MASK;
				r.year = y;
				if (y == '0) begin
					expected_words.push_back(make_word(none, CAPACITY, STAT_BADYEAR, 1'b1));
				end else if (stored_count >= CAPACITY) begin
					expected_words.push_back(make_word(none, CAPACITY, STAT_FULL, 1'b1));
				end else begin
					// stable: goes after every equal key
					pos = stored_count;
					while (pos > 0 && rec_key(stored_rec[pos - 1]) > rec_key(r)) begin
						stored_rec[pos] = stored_rec[pos - 1];
						pos--;
					end
					stored_rec[pos] = r;
					stored_count++;
					expected_words.push_back(make_word(r, pos, STAT_OK, 1'b1));
				end
			end
			KIND_FIND: begin
				qk = (key_sel == SEL_TITLE || key_sel == SEL_NAME) ? (q & KEY_MASK) : q;
				lo = 0;
				hi = stored_count - 1;
				hit = 1'b0;
				while (!hit && lo <= hi) begin
					mid = (lo + hi) / 2;
					v = rec_key(stored_rec[mid]);
					if (qk > v) begin
						lo = mid + 1;
					end else if (qk < v) begin
						hi = mid - 1;
					end else begin
						hit = 1'b1;
						expected_words.push_back(make_word(stored_rec[mid], mid, STAT_OK, 1'b1));
					end
				end
				if (!hit)
					expected_words.push_back(make_word(none, CAPACITY, STAT_NOTFOUND, 1'b1));
			end
			KIND_LIST: begin
				if (stored_count == 0)
					expected_words.push_back(make_word(none, CAPACITY, STAT_NOTFOUND, 1'b1));
				for (int i = 0; i < stored_count; i++)
					expected_words.push_back(make_word(stored_rec[i], i, STAT_OK,
						i == stored_count - 1));
			end
			default: begin
				stored_count = 0;
				expected_words.push_back(make_word(none, 0, STAT_OK, 1'b1));
			end
		endcase
	endtask

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", what, got, want));
	endtask

	always @(posedge clk) begin : watch
		res_t w;
		if (!arst_n) begin
			stored_count = 0;
			key_sel = SEL_TITLE;
			expected_words.delete();
		end else begin
			// results first: a word leaving now belongs to an earlier command
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("result word with nothing pending, title %h",
						out_title));
				end else begin
					w = expected_words.pop_front();
					check_field("out_title", out_title, w.rec.title);
					check_field("out_name", out_name, w.rec.name);
					check_field("out_year", 64'(out_year), 64'(w.rec.year));
					check_field("position", 64'(position), 64'(w.position));
					check_field("status", 64'(status), 64'(w.status));
					check_field("last", 64'(last), 64'(w.last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				key_sel = sort_field;
				stored_count = 0;
			end
			if (in_valid && !in_stall)
				predict_command(kind, title_key, name_key, year_value, query_key);
		end
		pending_words = expected_words.size();
	end

endmodule

// File: tb/sorted_record_table_search_core_test.sv
// ----------------------------------------------------------------------------
// sorted_record_table_search_core_test: regression for the sorted record table
// Directed commands over the empty, full and duplicate-key cases, then random
// phases under every sort key with sender gaps and receiver stalls; a checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module sorted_record_table_search_core_test;
	import srts_pkg::*;

	// sort key codes beyond the two the package names
	localparam logic [1:0] SEL_YEAR     = 2'd2;
	localparam logic [1:0] SEL_YEAR_ALT = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        kind;
	logic [KEY_W-1:0]  title_key;
	logic [KEY_W-1:0]  name_key;
	logic [YEAR_W-1:0] year_value;
	logic [KEY_W-1:0]  query_key;
	logic              out_valid;
	logic              out_stall;
	logic [KEY_W-1:0]  out_title;
	logic [KEY_W-1:0]  out_name;
	logic [YEAR_W-1:0] out_year;
	logic [POS_W-1:0]  position;
	logic [1:0]        status;
	logic              last;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        sort_field;

	int fail_count;
	int pending_words;

	// per-cycle odds, in percent, of a sender gap and of a receiver stall
	int idle_pct = 0;
	int stall_pct = 0;

	// key selected by the last config write; steers find queries toward hits
	logic [1:0] cur_sel = SEL_TITLE;

	// keys inserted under the current key, reused for duplicates and hits
	logic [KEY_W-1:0]  used_titles [$];
	logic [KEY_W-1:0]  used_names [$];
	logic [YEAR_W-1:0] used_years [$];

	always #5 clk = ~clk;

	sorted_record_table_search_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.title_key  (title_key),
		.name_key   (name_key),
		.year_value (year_value),
		.query_key  (query_key),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_title  (out_title),
		.out_name   (out_name),
		.out_year   (out_year),
		.position   (position),
		.status     (status),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.sort_field (sort_field)
	);

	sorted_record_table_search_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.title_key     (title_key),
		.name_key      (name_key),
		.year_value    (year_value),
		.query_key     (query_key),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_title     (out_title),
		.out_name      (out_name),
		.out_year      (out_year),
		.position      (position),
		.status        (status),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.sort_field    (sort_field),
		.fail_count    (fail_count),
		.pending_words (pending_words)
	);

	// Receiver: a fresh stall decision at every falling edge. With stall_pct
	// at zero the output drains as fast as the block offers words.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Hard stop, far beyond the slowest legal run (every command a full list
	// under heavy stalls).
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	// One command word. Entered and left at a falling edge. A gap drops valid
	// for whole cycles; once raised, valid and payload hold until the word is
	// taken. Valid is left high on return, so back-to-back words keep it up
	// without a lower/raise in the same step.
	task automatic send_word(kind_t k, logic [KEY_W-1:0] t, logic [KEY_W-1:0] n,
			logic [YEAR_W-1:0] y, logic [KEY_W-1:0] q);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		kind <= k;
		title_key <= t;
		name_key <= n;
		year_value <= y;
		query_key <= q;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and wait until the checker has nothing pending.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_words != 0)
			@(negedge clk);
	endtask

	// Config writes only with the block idle. Every command yields at least
	// one word, so an empty queue means the sequencer is back at rest.
	task automatic write_sort_field(logic [1:0] sel);
		drain_results();
		sort_field <= sel;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_sel = sel;
		// the write empties the table
		used_titles.delete();
		used_names.delete();
		used_years.delete();
	endtask

	// Random command, mostly well formed: inserts dominate so the table
	// fills (and sometimes overflows) between clears, finds usually aim at
	// a key that was inserted, and keys repeat to build runs of equal keys.
	task automatic random_word();
		int                r;
		int                idx;
		logic [KEY_W-1:0]  t;
		logic [KEY_W-1:0]  n;
		logic [KEY_W-1:0]  q;
		logic [YEAR_W-1:0] y;
		kind_t             k;
		t = {$urandom, $urandom};
		n = {$urandom, $urandom};
		q = {$urandom, $urandom};
		// small years collide often, which matters under the year key
		y = $urandom_range(1) ? YEAR_W'($urandom_range(1, 12))
			: YEAR_W'($urandom_range(1, 65535));
		if (used_titles.size() != 0 && $urandom_range(3) == 0) begin
			idx = $urandom_range(used_titles.size() - 1);
			t = used_titles[idx];
			n = used_names[idx];
		end
		r = $urandom_range(99);
		if (r < 55) begin
			k = KIND_INSERT;
			if (r < 4) begin
				y = '0;
			end else begin
				used_titles.push_back(t);
				used_names.push_back(n);
				used_years.push_back(y);
			end
		end else if (r < 78) begin
			k = KIND_FIND;
			if (used_titles.size() != 0 && $urandom_range(9) < 7) begin
				idx = $urandom_range(used_titles.size() - 1);
				case (cur_sel)
					SEL_TITLE: q = used_titles[idx];
					SEL_NAME:  q = used_names[idx];
					default:   q = {{(KEY_W - YEAR_W){1'b0}}, used_years[idx]};
				endcase
			end else if (cur_sel >= SEL_YEAR && $urandom_range(1) == 1) begin
				// near misses around the small years
				q = KEY_W'($urandom_range(0, 13));
			end
		end else if (r < 92) begin
			k = KIND_LIST;
		end else begin
			k = KIND_CLEAR;
		end
		send_word(k, t, n, y, q);
	endtask

	initial begin : stimulus
		logic [KEY_W-1:0]  t;
		logic [KEY_W-1:0]  n;
		logic [YEAR_W-1:0] y;
		logic [1:0]        sel;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_INSERT;
		title_key = '0;
		name_key = '0;
		year_value = '0;
		query_key = '0;
		cfg_valid = 1'b0;
		sort_field = SEL_TITLE;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_sort_field(SEL_TITLE);

		// empty table: list and find both miss, a year-zero insert is
		// rejected, a clear still answers
		send_word(KIND_LIST, '0, '0, '0, '0);
		send_word(KIND_FIND, '0, '0, '0, '1);
		send_word(KIND_INSERT, '1, '1, '0, '0);
		send_word(KIND_CLEAR, '0, '0, '0, '0);

		// fill to capacity: largest and smallest title, runs of equal
		// titles (stable order), extreme names and years
		for (int i = 0; i < CAPACITY; i++) begin
			t = (i == 0) ? '1 : (i == 1) ? '0 : {8'(i % 4), 56'h0};
			n = (i == 2) ? '1 : (i == 5) ? '0 : {$urandom, $urandom};
			y = (i == 3) ? '1 : (i == 4) ? YEAR_W'(1) : YEAR_W'($urandom_range(1, 65535));
			send_word(KIND_INSERT, t, n, y, '0);
		end
		// full table rejects, then a find inside a run of equal keys,
		// a find miss and a full list
		send_word(KIND_INSERT, {$urandom, $urandom}, {$urandom, $urandom}, YEAR_W'(1), '0);
		send_word(KIND_FIND, '0, '0, '0, {8'd2, 56'h0});
		send_word(KIND_FIND, '0, '0, '0, {8'd9, 56'h1});
		send_word(KIND_LIST, '0, '0, '0, '0);

		// random phases: every key code, idle patterns rotating
		for (int p = 0; p < 5; p++) begin
			case (p)
				0:       sel = SEL_NAME;
				1:       sel = SEL_YEAR;
				2:       sel = SEL_YEAR_ALT;
				3:       sel = SEL_TITLE;
				default: sel = SEL_YEAR;
			endcase
			write_sort_field(sel);
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 53; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 53; end
				default: begin idle_pct = 9; stall_pct = 9; end
			endcase
			for (int i = 0; i < 20; i++) begin
				random_word();
				// hold off mid-phase until every pending word is out
				if (p == 1 && i == 10)
					drain_results();
			end
		end

		drain_results();
		// longest command is a full list
		repeat (64) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
